@@ hdl/dfos_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfos_pkg: shared types and constants for the occlusion select unit
// Row layout of the face table, front/back transfer item, register map and
// the fixed thresholds of the selection tests.
// ----------------------------------------------------------------------------
package dfos_pkg;

   localparam int NUM_COORDS = 9;

   // one face: packed normal and three vertices (x,y,z per vertex, v1 first)
   typedef struct packed {
      logic [NUM_COORDS-1:0][31:0] vtx;
      logic [47:0]                 normal;
   } row_type;

   typedef logic [1:0] cls_type;
   localparam cls_type CLS_LOAD  = 2'd0;
   localparam cls_type CLS_SKIP  = 2'd1;
   localparam cls_type CLS_QUERY = 2'd2;
   localparam cls_type CLS_BAD   = 2'd3;

   typedef struct packed {
      cls_type     cls;
      logic [9:0]  idx;
      row_type     row;
   } item_type;

   typedef struct packed {
      logic [10:0]        count;
      logic signed [15:0] cos_max;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } cfg_type;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [2:0] REG_FACE_COUNT = 3'd0;
   localparam logic [2:0] REG_COS_MAX    = 3'd1;
   localparam logic [2:0] REG_DIR_X      = 3'd2;
   localparam logic [2:0] REG_DIR_Y      = 3'd3;
   localparam logic [2:0] REG_DIR_Z      = 3'd4;

   // dot product window (0.9999, 1.0001) in Q4.28, both ends excluded
   localparam logic signed [33:0] DOT_LOW_EXCL  = 34'sd268408612;
   localparam logic signed [33:0] DOT_HIGH_EXCL = 34'sd268462300;
   // |nz| > 0.001 in Q2.14
   localparam logic signed [15:0] NZ_LIMIT      = 16'sd16;

endpackage
`default_nettype wire

@@ hdl/dfos_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfos_fifo: two-entry item queue
// Decouples the accepting front from the executing back.
// ----------------------------------------------------------------------------
module dfos_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire dfos_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_pop,
   output dfos_pkg::item_type     out_item
);

   dfos_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

@@ hdl/dfos_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfos_front: input stage and classifier
// Registers each accepted item and tags it as load, skipped load, query or
// out-of-range query before it enters the queue.
// ----------------------------------------------------------------------------
module dfos_front #(
   parameter int MAX_FACES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [9:0]  req_face_index,
   input  wire logic [47:0] req_normal_packed,
   input  wire logic [31:0] req_v1_x,
   input  wire logic [31:0] req_v1_y,
   input  wire logic [31:0] req_v1_z,
   input  wire logic [31:0] req_v2_x,
   input  wire logic [31:0] req_v2_y,
   input  wire logic [31:0] req_v2_z,
   input  wire logic [31:0] req_v3_x,
   input  wire logic [31:0] req_v3_y,
   input  wire logic [31:0] req_v3_z,
   input  wire logic [10:0] face_count,
   output logic             push_valid,
   input  wire logic        push_ready,
   output dfos_pkg::item_type push_item
);

   logic               stage_valid_ff, stage_valid_in;
   dfos_pkg::item_type stage_item_ff, stage_item_in;
   logic               accept;
   logic               load_in_range;

   assign req_ready  = !stage_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = stage_valid_ff;
   assign push_item  = stage_item_ff;

   assign load_in_range = (32'(req_face_index) < 32'(MAX_FACES));

   always_comb begin
      stage_item_in.idx           = req_face_index;
      stage_item_in.row.normal    = req_normal_packed;
      stage_item_in.row.vtx[0]    = req_v1_x;
      stage_item_in.row.vtx[1]    = req_v1_y;
      stage_item_in.row.vtx[2]    = req_v1_z;
      stage_item_in.row.vtx[3]    = req_v2_x;
      stage_item_in.row.vtx[4]    = req_v2_y;
      stage_item_in.row.vtx[5]    = req_v2_z;
      stage_item_in.row.vtx[6]    = req_v3_x;
      stage_item_in.row.vtx[7]    = req_v3_y;
      stage_item_in.row.vtx[8]    = req_v3_z;
      if (req_opcode == dfos_pkg::OP_LOAD) begin
         stage_item_in.cls = load_in_range ? dfos_pkg::CLS_LOAD : dfos_pkg::CLS_SKIP;
      end else if ({1'b0, req_face_index} >= face_count) begin
         stage_item_in.cls = dfos_pkg::CLS_BAD;
      end else begin
         stage_item_in.cls = dfos_pkg::CLS_QUERY;
      end
      stage_valid_in = accept || (stage_valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff <= stage_item_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/dfos_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfos_back: face table and query engine
// Writes loads into the face table; for a query, runs the angle test on the
// queried face and, if it passes, streams every counted face through a
// three-stage occlusion pipeline; the result is registered.
// ----------------------------------------------------------------------------
module dfos_back #(
   parameter int MAX_FACES = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   output logic                    item_pop,
   input  wire dfos_pkg::item_type item,
   input  wire dfos_pkg::cfg_type  cfg,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [9:0]              rsp_result_index,
   output logic                    rsp_selected,
   output logic                    rsp_bad_index
);

   localparam int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FETCH = 4'd1;
   localparam logic [3:0] ST_M1    = 4'd2;
   localparam logic [3:0] ST_M2    = 4'd3;
   localparam logic [3:0] ST_M3    = 4'd4;
   localparam logic [3:0] ST_M4    = 4'd5;
   localparam logic [3:0] ST_M5    = 4'd6;
   localparam logic [3:0] ST_WALK  = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   function automatic logic signed [32:0] sub33(logic [31:0] a, logic [31:0] b);
      return {a[31], a} - {b[31], b};
   endfunction

   // face table
   dfos_pkg::row_type mem [MAX_FACES];
   dfos_pkg::row_type rd_row_ff;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(item.idx)] <= item.row;
      end
      rd_row_ff <= mem[rd_addr];
   end

   // control
   logic [3:0]  state_ff, state_in;
   logic [9:0]  idx_ff, idx_in;
   logic [10:0] j_ff, j_in;
   logic        p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic        occl_ff, occl_in;
   logic        sel_ff, sel_in;
   logic        bad_ff, bad_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [9:0]  rsp_idx_ff;
   logic        rsp_sel_ff, rsp_bad_ff;
   logic        rsp_load;
   logic        issue;

   // queried face and angle test
   dfos_pkg::row_type  row_i_ff;
   logic signed [15:0] nix, niy, niz;
   logic signed [31:0] pdx_ff, pdy_ff, pdz_ff;
   logic signed [31:0] sqnx_ff, sqny_ff, sqnz_ff, sqdx_ff, sqdy_ff, sqdz_ff;
   logic signed [33:0] dot_in, l1_w, l2_w;
   logic signed [33:0] dot_ff;
   logic [31:0]        dabs_ff, l1_ff, l2_ff;
   logic [15:0]        cabs;
   logic [63:0]        lp_ff, dm_ff, dm2_ff, rlo_ff, rhi_ff;
   logic [31:0]        c2_ff;
   logic               lz_ff;
   logic [95:0]        lhs, rhs;
   logic               dn, cn, angle_ok, window;

   // occlusion pipeline
   logic signed [32:0] e_ff [3][3];
   logic signed [32:0] pbx_ff [3];
   logic signed [32:0] pby_ff [3];
   logic signed [32:0] bax_ff, bay_ff, cax_ff, cay_ff, cbx_ff, cby_ff;
   logic signed [15:0] nj_ff [3];
   logic signed [15:0] nz2_ff;
   logic signed [48:0] dp_ff [3][3];
   logic signed [65:0] pa_ff [3];
   logic signed [65:0] qa_ff [3];
   logic signed [65:0] pb_ff [3];
   logic signed [65:0] qb_ff [3];
   logic signed [65:0] pc_ff [3];
   logic signed [65:0] qc_ff [3];
   logic signed [50:0] dsum [3];
   logic [2:0]         vtx_in_tri;
   logic               all_ge, all_le, side_ok, hit;

   assign nix = row_i_ff.normal[15:0];
   assign niy = row_i_ff.normal[31:16];
   assign niz = row_i_ff.normal[47:32];

   assign dot_in = pdx_ff + pdy_ff + pdz_ff;
   assign l1_w   = sqnx_ff + sqny_ff + sqnz_ff;
   assign l2_w   = sqdx_ff + sqdy_ff + sqdz_ff;
   assign cabs   = cfg.cos_max[15] ? 16'(-cfg.cos_max) : 16'(cfg.cos_max);

   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH) begin
         row_i_ff <= rd_row_ff;
      end
      pdx_ff  <= nix * cfg.dir_x;
      pdy_ff  <= niy * cfg.dir_y;
      pdz_ff  <= niz * cfg.dir_z;
      sqnx_ff <= nix * nix;
      sqny_ff <= niy * niy;
      sqnz_ff <= niz * niz;
      sqdx_ff <= cfg.dir_x * cfg.dir_x;
      sqdy_ff <= cfg.dir_y * cfg.dir_y;
      sqdz_ff <= cfg.dir_z * cfg.dir_z;
      dot_ff  <= dot_in;
      dabs_ff <= dot_in[33] ? 32'(-dot_in) : dot_in[31:0];
      l1_ff   <= l1_w[31:0];
      l2_ff   <= l2_w[31:0];
      lp_ff   <= 64'(l1_ff) * 64'(l2_ff);
      dm_ff   <= 64'(dabs_ff) * 64'(dabs_ff);
      c2_ff   <= 32'(cabs) * 32'(cabs);
      rlo_ff  <= 64'(c2_ff) * 64'(lp_ff[31:0]);
      rhi_ff  <= 64'(c2_ff) * 64'(lp_ff[63:32]);
      lz_ff   <= (lp_ff == 64'd0);
      dm2_ff  <= dm_ff;
   end

   // squared comparison: dot^2 * 2^28 against cos^2 * |n|^2 * |dir|^2
   always_comb begin
      lhs      = {4'd0, dm2_ff, 28'd0};
      rhs      = {rhi_ff, 32'd0} + 96'(rlo_ff);
      dn       = dot_ff[33];
      cn       = cfg.cos_max[15];
      angle_ok = !lz_ff && ((!dn && cn) || ((dn == cn) && (dn ? (lhs < rhs) : (lhs > rhs))));
      window   = (dot_ff > dfos_pkg::DOT_LOW_EXCL) && (dot_ff < dfos_pkg::DOT_HIGH_EXCL);
   end

   // stage 1: differences against face j, stage 2: products
   always_ff @(posedge clock) begin
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            e_ff[v][k] <= sub33(row_i_ff.vtx[3*v+k], rd_row_ff.vtx[k]);
         end
         pbx_ff[v] <= sub33(row_i_ff.vtx[3*v], rd_row_ff.vtx[3]);
         pby_ff[v] <= sub33(row_i_ff.vtx[3*v+1], rd_row_ff.vtx[4]);
      end
      bax_ff   <= sub33(rd_row_ff.vtx[3], rd_row_ff.vtx[0]);
      bay_ff   <= sub33(rd_row_ff.vtx[4], rd_row_ff.vtx[1]);
      cax_ff   <= sub33(rd_row_ff.vtx[6], rd_row_ff.vtx[0]);
      cay_ff   <= sub33(rd_row_ff.vtx[7], rd_row_ff.vtx[1]);
      cbx_ff   <= sub33(rd_row_ff.vtx[6], rd_row_ff.vtx[3]);
      cby_ff   <= sub33(rd_row_ff.vtx[7], rd_row_ff.vtx[4]);
      nj_ff[0] <= rd_row_ff.normal[15:0];
      nj_ff[1] <= rd_row_ff.normal[31:16];
      nj_ff[2] <= rd_row_ff.normal[47:32];

      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            dp_ff[v][k] <= e_ff[v][k] * nj_ff[k];
         end
         pa_ff[v] <= bax_ff * e_ff[v][1];
         qa_ff[v] <= bay_ff * e_ff[v][0];
         pb_ff[v] <= cax_ff * e_ff[v][1];
         qb_ff[v] <= cay_ff * e_ff[v][0];
         pc_ff[v] <= cbx_ff * pby_ff[v];
         qc_ff[v] <= cby_ff * pbx_ff[v];
      end
      nz2_ff <= nj_ff[2];
   end

   // stage 3: side test and point-in-triangle for each vertex
   always_comb begin
      all_ge = 1'b1;
      all_le = 1'b1;
      for (int v = 0; v < 3; v++) begin
         dsum[v] = dp_ff[v][0] + dp_ff[v][1] + dp_ff[v][2];
         if (dsum[v] < 0) begin
            all_ge = 1'b0;
         end
         if (dsum[v] > 0) begin
            all_le = 1'b0;
         end
         vtx_in_tri[v] = ((pb_ff[v] >= qb_ff[v]) != (pa_ff[v] >= qa_ff[v])) &&
                         ((pc_ff[v] >= qc_ff[v]) == (pa_ff[v] >= qa_ff[v]));
      end
      side_ok = (all_ge && (nz2_ff > dfos_pkg::NZ_LIMIT)) ||
                (all_le && (nz2_ff < -dfos_pkg::NZ_LIMIT));
      hit = side_ok && (|vtx_in_tri);
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      occl_in      = occl_ff;
      sel_in       = sel_ff;
      bad_in       = bad_ff;
      item_pop     = 1'b0;
      mem_we       = 1'b0;
      rd_addr      = AW'(j_ff);
      issue        = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               case (item.cls)
                  dfos_pkg::CLS_LOAD: begin
                     mem_we = 1'b1;
                  end
                  dfos_pkg::CLS_QUERY: begin
                     rd_addr  = AW'(item.idx);
                     idx_in   = item.idx;
                     bad_in   = 1'b0;
                     state_in = ST_FETCH;
                  end
                  dfos_pkg::CLS_BAD: begin
                     idx_in   = item.idx;
                     bad_in   = 1'b1;
                     sel_in   = 1'b0;
                     state_in = ST_DONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: state_in = ST_M1;
         ST_M1:    state_in = ST_M2;
         ST_M2:    state_in = ST_M3;
         ST_M3:    state_in = ST_M4;
         ST_M4:    state_in = ST_M5;
         ST_M5: begin
            sel_in   = angle_ok || window;
            j_in     = 11'd0;
            occl_in  = 1'b0;
            state_in = (angle_ok || window) ? ST_WALK : ST_DONE;
         end
         ST_WALK: begin
            if (j_ff < cfg.count) begin
               issue = 1'b1;
               j_in  = j_ff + 11'd1;
            end else if (!p0_ff && !p1_ff && !p2_ff) begin
               sel_in   = sel_ff && !occl_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // hold the first hit; later faces cannot clear it
      if (p2_ff && hit) begin
         occl_in = 1'b1;
      end
      p0_in = issue;
      p1_in = p0_ff;
      p2_in = p1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p0_ff        <= 1'b0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p0_ff        <= p0_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      j_ff    <= j_in;
      occl_ff <= occl_in;
      sel_ff  <= sel_in;
      bad_ff  <= bad_in;
      if (rsp_load) begin
         rsp_idx_ff <= idx_ff;
         rsp_sel_ff <= sel_ff;
         rsp_bad_ff <= bad_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_selected     = rsp_sel_ff;
   assign rsp_bad_index    = rsp_bad_ff;

endmodule
`default_nettype wire

@@ hdl/downward_face_occlusion_select_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// downward_face_occlusion_select_unit: face selection with occlusion search
// Top level: configuration registers, input stage, item queue, query engine.
// ----------------------------------------------------------------------------
// Loads write one face (normal and three vertices) into a table of MAX_FACES
// rows with one write port and one read port. A query gives one result: an
// index not below face_count returns with bad_index set and no tests run;
// otherwise the angle test runs first, and a selected face then walks all
// face_count stored faces through the table's one read port, one face per
// cycle. Up to three items are buffered ahead of the engine, so the input
// keeps taking items while a query runs or a result waits, until the buffer
// is full. Registers: face_count at 0x00, cos_max_angle at 0x04, dir_x/y/z
// at 0x08/0x0C/0x10; write them only while idle.
module downward_face_occlusion_select_unit #(
   parameter int MAX_FACES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [9:0]  req_face_index,
   input  wire logic [47:0] req_normal_packed,
   input  wire logic [31:0] req_v1_x,
   input  wire logic [31:0] req_v1_y,
   input  wire logic [31:0] req_v1_z,
   input  wire logic [31:0] req_v2_x,
   input  wire logic [31:0] req_v2_y,
   input  wire logic [31:0] req_v2_z,
   input  wire logic [31:0] req_v3_x,
   input  wire logic [31:0] req_v3_y,
   input  wire logic [31:0] req_v3_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [9:0]       rsp_result_index,
   output logic             rsp_selected,
   output logic             rsp_bad_index,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int unsigned COUNT_CAP = (MAX_FACES > 2047) ? 2047 : MAX_FACES;

   logic [10:0]        face_count_ff;
   logic signed [15:0] cos_max_ff, dir_x_ff, dir_y_ff, dir_z_ff;
   logic [10:0]        count_eff;
   logic               csr_write;
   dfos_pkg::cfg_type  cfg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_count_ff <= 11'd0;
         cos_max_ff    <= 16'sd16384;
         dir_x_ff      <= 16'sd0;
         dir_y_ff      <= 16'sd0;
         dir_z_ff      <= -16'sd16384;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            dfos_pkg::REG_FACE_COUNT: face_count_ff <= csr_pwdata[10:0];
            dfos_pkg::REG_COS_MAX:    cos_max_ff    <= csr_pwdata[15:0];
            dfos_pkg::REG_DIR_X:      dir_x_ff      <= csr_pwdata[15:0];
            dfos_pkg::REG_DIR_Y:      dir_y_ff      <= csr_pwdata[15:0];
            dfos_pkg::REG_DIR_Z:      dir_z_ff      <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         dfos_pkg::REG_FACE_COUNT: csr_prdata = {21'd0, face_count_ff};
         dfos_pkg::REG_COS_MAX:    csr_prdata = 32'(cos_max_ff);
         dfos_pkg::REG_DIR_X:      csr_prdata = 32'(dir_x_ff);
         dfos_pkg::REG_DIR_Y:      csr_prdata = 32'(dir_y_ff);
         dfos_pkg::REG_DIR_Z:      csr_prdata = 32'(dir_z_ff);
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // saturate the count to the table depth
   assign count_eff = (32'(face_count_ff) > COUNT_CAP) ? 11'(COUNT_CAP) : face_count_ff;

   always_comb begin
      cfg.count   = count_eff;
      cfg.cos_max = cos_max_ff;
      cfg.dir_x   = dir_x_ff;
      cfg.dir_y   = dir_y_ff;
      cfg.dir_z   = dir_z_ff;
   end

   logic               push_valid, push_ready;
   dfos_pkg::item_type push_item;
   logic               q_valid, q_pop;
   dfos_pkg::item_type q_item;

   dfos_front #(
      .MAX_FACES(MAX_FACES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_face_index   (req_face_index),
      .req_normal_packed(req_normal_packed),
      .req_v1_x         (req_v1_x),
      .req_v1_y         (req_v1_y),
      .req_v1_z         (req_v1_z),
      .req_v2_x         (req_v2_x),
      .req_v2_y         (req_v2_y),
      .req_v2_z         (req_v2_z),
      .req_v3_x         (req_v3_x),
      .req_v3_y         (req_v3_y),
      .req_v3_z         (req_v3_z),
      .face_count       (count_eff),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_item        (push_item)
   );

   dfos_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .in_valid (push_valid),
      .in_ready (push_ready),
      .in_item  (push_item),
      .out_valid(q_valid),
      .out_pop  (q_pop),
      .out_item (q_item)
   );

   dfos_back #(
      .MAX_FACES(MAX_FACES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (q_valid),
      .item_pop        (q_pop),
      .item            (q_item),
      .cfg             (cfg),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_index(rsp_result_index),
      .rsp_selected    (rsp_selected),
      .rsp_bad_index   (rsp_bad_index)
   );

endmodule
`default_nettype wire
